// ===== rtl/mef_pkg.sv =====
// Package for the majority element finder.
// Holds sizes, beat structs and the sequencer state type; depends on nothing.
`timescale 1ns / 1ps

package mef_pkg;

	localparam int DEPTH       = 1024;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic               found;
		logic signed [31:0] majority;
		logic [10:0]        occurrences;
		logic               overflow;
	} result_t;

	typedef struct packed {
		logic                   en;
		logic [ADDR_W-1:0]      addr;
		logic [VALUE_WIDTH-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic                   go;
		logic [VALUE_WIDTH-1:0] cand;
		logic [CNT_W-1:0]       len;
	} scan_req_t;

	typedef enum logic {
		ST_LOAD,
		ST_SCAN
	} state_t;

endpackage

// ===== rtl/mef_scan.sv =====
// Element store and the counting pass that checks a candidate against it.
// Depends on mef_pkg.
`timescale 1ns / 1ps

module mef_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mef_pkg::mem_wr_t            wr,
	input  mef_pkg::scan_req_t          req,
	output logic                        done,
	output logic [mef_pkg::CNT_W-1:0]   occ
);

	logic [mef_pkg::VALUE_WIDTH-1:0] mem [mef_pkg::DEPTH];

	logic                            active_q;
	logic [mef_pkg::CNT_W-1:0]       rd_cnt_q;
	logic                            rd_vld_s1;
	logic [mef_pkg::VALUE_WIDTH-1:0] rdata_s1;
	logic [mef_pkg::CNT_W-1:0]       occ_q;
	logic                            issue;
	logic                            finish;

	assign issue  = active_q && (rd_cnt_q < req.len);
	assign finish = active_q && (rd_cnt_q == req.len) && !rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (issue) begin
			rdata_s1 <= mem[rd_cnt_q[mef_pkg::ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
			occ_q     <= '0;
		end else begin
			rd_vld_s1 <= issue;
			if (req.go) begin
				active_q <= 1'b1;
				rd_cnt_q <= '0;
				occ_q    <= '0;
			end else begin
				if (issue) begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end
				if (rd_vld_s1 && (rdata_s1 == req.cand)) begin
					occ_q <= occ_q + 1'b1;
				end
				if (finish) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	assign done = finish;
	assign occ  = occ_q;

endmodule

// ===== rtl/majority_element_finder.sv =====
// Majority element finder: one beat per cycle while loading, then a count pass.
// After the last beat, the stored set is checked by a count pass that reads it through
// the single read port of the element store; busy is high during that pass.
// The result beat is a one-cycle strobe on done and cannot be stalled.
// Reset clears the set counters and the sequencer; store contents stay undefined.
// Depends on mef_pkg and mef_scan.
`timescale 1ns / 1ps

module majority_element_finder (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mef_pkg::item_t   item,
	output logic             done,
	output mef_pkg::result_t result
);

	mef_pkg::state_t                 state_q, state_d;
	logic [mef_pkg::CNT_W-1:0]       count_q;
	logic [mef_pkg::VALUE_WIDTH-1:0] cand_q;
	logic [mef_pkg::CNT_W-1:0]       vote_q;
	logic                            ovf_q;
	logic                            done_q;
	mef_pkg::result_t                result_q;

	logic                            accept;
	logic                            room;
	logic [mef_pkg::VALUE_WIDTH-1:0] v;
	logic                            scan_done;
	logic [mef_pkg::CNT_W-1:0]       occ;
	logic                            found;
	mef_pkg::mem_wr_t                wr;
	mef_pkg::scan_req_t              req;

	assign v    = item.value[mef_pkg::VALUE_WIDTH-1:0];
	assign room = count_q < mef_pkg::CNT_W'(mef_pkg::DEPTH);

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		unique case (state_q)
			mef_pkg::ST_LOAD: begin
				busy = 1'b0;
				if (start && item.last) begin
					state_d = mef_pkg::ST_SCAN;
				end
			end
			mef_pkg::ST_SCAN: begin
				busy = 1'b1;
				if (scan_done) begin
					state_d = mef_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = mef_pkg::ST_LOAD;
			end
		endcase
	end

	assign accept = start && !busy;

	assign wr.en   = accept && room;
	assign wr.addr = count_q[mef_pkg::ADDR_W-1:0];
	assign wr.data = v;

	assign req.go   = accept && item.last;
	assign req.cand = cand_q;
	assign req.len  = count_q;

	mef_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.req    (req),
		.done   (scan_done),
		.occ    (occ)
	);

	assign found = {occ, 1'b0} > {1'b0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mef_pkg::ST_LOAD;
			count_q <= '0;
			cand_q  <= '0;
			vote_q  <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= scan_done;
			if (accept) begin
				if (room) begin
					count_q <= count_q + 1'b1;
					if (vote_q == '0) begin
						cand_q <= v;
						vote_q <= mef_pkg::CNT_W'(1);
					end else if (cand_q == v) begin
						vote_q <= vote_q + 1'b1;
					end else begin
						vote_q <= vote_q - 1'b1;
					end
				end else begin
					ovf_q <= 1'b1;
				end
			end else if (scan_done) begin
				count_q <= '0;
				cand_q  <= '0;
				vote_q  <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_done) begin
			result_q.found       <= found;
			result_q.majority    <= found ? 32'(cand_q) : '0;
			result_q.occurrences <= 11'(occ);
			result_q.overflow    <= ovf_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a preceding count pass");

	a_ready_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("block still busy when the result beat is shown");

	a_occ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.occurrences <= 11'($past(count_q))))
		else $error("occurrence count exceeds the stored element count");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mef_pkg::CNT_W'(mef_pkg::DEPTH))
		else $error("element count beyond store depth");

	a_found_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.found) |-> (result.occurrences != 11'd0))
		else $error("majority reported with no occurrences");

endmodule

// ===== tb/majority_vote_checker.sv =====
// Checker for the majority element finder: watches the item and result beats,
// keeps its own vote, store and count, and compares every result beat.
// Depends on mef_pkg.
`timescale 1ns / 1ps

module majority_vote_checker
	import mef_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  logic    done,
	input  result_t result,
	output int      mismatches,
	output int      awaited
);

	logic [VALUE_WIDTH-1:0] kept_values [DEPTH];
	int                     kept_count;
	logic [VALUE_WIDTH-1:0] leader;
	int                     lead_margin;
	logic                   dropped_any;
	result_t                verdicts_due [$];

	task automatic clear_set();
		kept_count  = 0;
		leader      = '0;
		lead_margin = 0;
		dropped_any = 1'b0;
	endtask

	task automatic absorb_element(input item_t beat);
		logic [VALUE_WIDTH-1:0] v;
		int                     hits;
		result_t                verdict;
		v = beat.value[VALUE_WIDTH-1:0];
		if (kept_count < DEPTH) begin
			kept_values[kept_count] = v;
			kept_count++;
			if (lead_margin == 0) begin
				leader      = v;
				lead_margin = 1;
			end else if (leader == v) begin
				lead_margin++;
			end else begin
				lead_margin--;
			end
		end else begin
			dropped_any = 1'b1;
		end
		if (beat.last) begin
			hits = 0;
			for (int i = 0; i < kept_count; i++) begin
				if (kept_values[i] == leader)
					hits++;
			end
			verdict.found       = (kept_count > 0) && (hits * 2 > kept_count);
			verdict.majority    = verdict.found ? 32'(leader) : '0;
			verdict.occurrences = 11'(hits);
			verdict.overflow    = dropped_any;
			verdicts_due.push_back(verdict);
			clear_set();
		end
	endtask

	task automatic compare_result(input result_t got);
		result_t want;
		if (verdicts_due.size() == 0) begin
			$error("result beat with no result awaited: %p", got);
			mismatches++;
		end else begin
			want = verdicts_due.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				mismatches++;
			end
			if (got.majority !== want.majority) begin
				$error("majority: expected %0d, got %0d", want.majority, got.majority);
				mismatches++;
			end
			if (got.occurrences !== want.occurrences) begin
				$error("occurrences: expected %0d, got %0d",
					want.occurrences, got.occurrences);
				mismatches++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_set();
			verdicts_due.delete();
			mismatches = 0;
			awaited    = 0;
		end else begin
			if (start && !busy)
				absorb_element(item);
			if (done)
				compare_result(result);
			awaited = verdicts_due.size();
		end
	end

endmodule

// ===== tb/majority_element_finder_test.sv =====
// Top of the majority element finder testbench: clock, reset, directed and random sets
// with varying sender gaps, and the verdict. Depends on mef_pkg, the block and
// majority_vote_checker.
`timescale 1ns / 1ps

module majority_element_finder_test;
	import mef_pkg::*;

	localparam int                 RANDOM_ITEMS = 950;
	localparam int                 CYCLE_LIMIT  = 400000;
	localparam logic signed [31:0] VALUE_MIN    = 32'sh8000_0000;
	localparam logic signed [31:0] VALUE_MAX    = 32'sh7fff_ffff;

	typedef enum int {
		SHAPE_PLANTED,
		SHAPE_HALF,
		SHAPE_POOL,
		SHAPE_SCATTER
	} set_shape_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;
	int      mismatches;
	int      awaited;
	int      cycle_count;
	int      sender_idle_pct;
	int      random_sent;

	logic signed [31:0] set_values [$];

	majority_element_finder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	majority_vote_checker checker_inst (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.done       (done),
		.result     (result),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("majority_element_finder verification failed");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(7))
			0: return VALUE_MIN;
			1: return VALUE_MAX;
			2: return '0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_element(input logic signed [31:0] v, input logic is_last);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= item_t'{value: v, last: is_last};
		do @(posedge clk); while (busy);
	endtask

	task automatic send_set();
		for (int i = 0; i < set_values.size(); i++)
			send_element(set_values[i], i == set_values.size() - 1);
	endtask

	task automatic shuffle_set();
		int                 j;
		logic signed [31:0] tmp;
		for (int i = set_values.size() - 1; i > 0; i--) begin
			j             = $urandom_range(i);
			tmp           = set_values[i];
			set_values[i] = set_values[j];
			set_values[j] = tmp;
		end
	endtask

	task automatic build_random_set();
		int                 size;
		set_shape_t         shape;
		logic signed [31:0] lead;
		logic signed [31:0] pool [3];
		set_values.delete();
		size  = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		shape = set_shape_t'($urandom_range(3));
		lead  = pick_value();
		for (int k = 0; k < 3; k++)
			pool[k] = pick_value();
		for (int i = 0; i < size; i++) begin
			case (shape)
				SHAPE_PLANTED: set_values.push_back(i <= size / 2 ? lead : pick_value());
				SHAPE_HALF:    set_values.push_back(i < size / 2 ? lead : pick_value());
				SHAPE_POOL:    set_values.push_back(pool[$urandom_range(2)]);
				default:       set_values.push_back(pick_value());
			endcase
		end
		shuffle_set();
	endtask

	initial begin
		logic signed [31:0] lead;
		arst_n          = 1'b0;
		start           = 1'b0;
		item            = '0;
		sender_idle_pct = 22;
		random_sent     = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		set_values = '{VALUE_MIN};
		send_set();
		set_values = '{VALUE_MAX};
		send_set();
		set_values = '{32'sd0, -32'sd1, -32'sd1};
		send_set();
		set_values = '{32'sd5, 32'sd5, 32'sd7, 32'sd7};
		send_set();
		set_values = '{32'sd1, 32'sd2, 32'sd3};
		send_set();
		set_values = '{32'sh5555_5555, 32'shaaaa_aaaa, 32'shaaaa_aaaa};
		send_set();

		while (random_sent < RANDOM_ITEMS) begin
			if (random_sent < RANDOM_ITEMS / 3)
				sender_idle_pct = 22;
			else if (random_sent < 2 * RANDOM_ITEMS / 3)
				sender_idle_pct = 81;
			else
				sender_idle_pct = 0;
			build_random_set();
			random_sent += set_values.size();
			send_set();
		end

		// A full store of one value, then two more beats that must be dropped.
		lead = pick_value();
		set_values.delete();
		for (int i = 0; i < DEPTH + 2; i++)
			set_values.push_back(i < DEPTH ? lead : pick_value());
		send_set();

		start <= 1'b0;
		@(posedge clk);
		wait (awaited == 0);
		repeat (32) @(posedge clk);
		if (mismatches == 0 && awaited == 0) begin
			$display("majority_element_finder verification clean");
		end else begin
			$display("majority_element_finder verification failed");
		end
		$finish;
	end

endmodule
